// ----- design/sbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbsc_pkg
// Types, register indexes, result codes and helpers shared by the spectral
// band symptom classifier and its checker.
// ----------------------------------------------------------------------------
package sbsc_pkg;

    // Fixed field widths
    localparam int BinWidth  = 5;
    localparam int MagWidth  = 20;
    localparam int RunWidth  = 4;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 20;

    // Bins at or above this number never count toward a peak
    localparam int SpectrumBins = 32;

    localparam int DefCooldownFrames = 2;

    // Stream packing
    localparam int InDataWidth  = 32;   // bin_index, magnitude, zero fill
    localparam int OutDataWidth = 48;   // symptom, intensity, led mode, peaks, fill

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_TREMOR_BIN_LOW  = 3'd0,
        REG_TREMOR_BIN_HIGH = 3'd1,
        REG_DYSK_BIN_LOW    = 3'd2,
        REG_DYSK_BIN_HIGH   = 3'd3,
        REG_THRESH_LOW      = 3'd4,
        REG_THRESH_MEDIUM   = 3'd5,
        REG_THRESH_HIGH     = 3'd6,
        REG_MIN_CONSECUTIVE = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        SYM_NONE   = 2'd0,
        SYM_TREMOR = 2'd1,
        SYM_DYSK   = 2'd2
    } symptom_t;

    typedef enum logic [1:0] {
        LVL_NONE   = 2'd0,
        LVL_LOW    = 2'd1,
        LVL_MEDIUM = 2'd2,
        LVL_HIGH   = 2'd3
    } intensity_t;

    typedef enum logic [1:0] {
        LED_OFF   = 2'd0,
        LED_BLINK = 2'd1,
        LED_SOLID = 2'd2
    } led_mode_t;

    // Per-band figures of the folded frame peak
    typedef struct packed {
        logic       detect;   // peak strictly above the low threshold
        intensity_t level;    // peak against high, medium, low thresholds
    } band_stat_t;

    typedef struct packed {
        symptom_t   symptom;
        intensity_t intensity;
        led_mode_t  led_mode;
    } verdict_t;

    function automatic intensity_t level_of(
        input logic [MagWidth-1:0] mag,
        input logic [MagWidth-1:0] th_low,
        input logic [MagWidth-1:0] th_medium,
        input logic [MagWidth-1:0] th_high
    );
        intensity_t lvl;
        priority if (mag >= th_high) begin
            lvl = LVL_HIGH;
        end else if (mag >= th_medium) begin
            lvl = LVL_MEDIUM;
        end else if (mag >= th_low) begin
            lvl = LVL_LOW;
        end else begin
            lvl = LVL_NONE;
        end
        return lvl;
    endfunction

endpackage

// ----- design/sbsc_decide.sv -----
// ----------------------------------------------------------------------------
// sbsc_decide
// Frame decision: run counters per band, dyskinesia priority, tremor
// cooldown after dyskinesia ends, and the symptom/intensity/LED verdict.
// ----------------------------------------------------------------------------
module sbsc_decide #(
    parameter int COOLDOWN_FRAMES = sbsc_pkg::DefCooldownFrames
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            frame_end,
    input  logic [sbsc_pkg::RunWidth-1:0]   min_consecutive,
    input  sbsc_pkg::band_stat_t            tremor_stat,
    input  sbsc_pkg::band_stat_t            dysk_stat,
    output sbsc_pkg::verdict_t              verdict
);

    localparam int CdWidth = (COOLDOWN_FRAMES > 0) ? $clog2(COOLDOWN_FRAMES + 1) : 1;

    logic [sbsc_pkg::RunWidth-1:0] tremor_run_reg, tremor_run_next;
    logic [sbsc_pkg::RunWidth-1:0] dysk_run_reg, dysk_run_next;
    logic                          dysk_was_active_reg, dysk_was_active_next;
    logic [CdWidth-1:0]            cooldown_reg, cooldown_next;

    logic               tremor_act;
    logic               dysk_act;
    logic [CdWidth-1:0] cooldown_eff;
    logic               suppressed;

    always_comb begin
        // Runs clear on a miss and saturate at the required count
        if (!tremor_stat.detect) begin
            tremor_run_next = '0;
        end else if (tremor_run_reg < min_consecutive) begin
            tremor_run_next = tremor_run_reg + sbsc_pkg::RunWidth'(1);
        end else begin
            tremor_run_next = tremor_run_reg;
        end

        if (!dysk_stat.detect) begin
            dysk_run_next = '0;
        end else if (dysk_run_reg < min_consecutive) begin
            dysk_run_next = dysk_run_reg + sbsc_pkg::RunWidth'(1);
        end else begin
            dysk_run_next = dysk_run_reg;
        end

        tremor_act = (tremor_run_next >= min_consecutive);
        dysk_act   = (dysk_run_next >= min_consecutive);

        // Falling edge of dyskinesia restarts the cooldown, this frame included
        if (dysk_was_active_reg && !dysk_act) begin
            cooldown_eff = CdWidth'(COOLDOWN_FRAMES);
        end else begin
            cooldown_eff = cooldown_reg;
        end
        suppressed    = (cooldown_eff != '0);
        cooldown_next = suppressed ? cooldown_eff - CdWidth'(1) : cooldown_eff;

        dysk_was_active_next = dysk_act;
    end

    always_comb begin
        verdict.symptom   = sbsc_pkg::SYM_NONE;
        verdict.intensity = sbsc_pkg::LVL_NONE;
        verdict.led_mode  = sbsc_pkg::LED_OFF;
        priority if (dysk_act) begin
            verdict.symptom   = sbsc_pkg::SYM_DYSK;
            verdict.intensity = dysk_stat.level;
        end else if (tremor_act && !suppressed) begin
            verdict.symptom   = sbsc_pkg::SYM_TREMOR;
            verdict.intensity = tremor_stat.level;
        end else begin
            verdict.symptom   = sbsc_pkg::SYM_NONE;
            verdict.intensity = sbsc_pkg::LVL_NONE;
        end
        unique case (verdict.intensity)
            sbsc_pkg::LVL_MEDIUM: verdict.led_mode = sbsc_pkg::LED_BLINK;
            sbsc_pkg::LVL_HIGH:   verdict.led_mode = sbsc_pkg::LED_SOLID;
            default:              verdict.led_mode = sbsc_pkg::LED_OFF;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tremor_run_reg      <= '0;
            dysk_run_reg        <= '0;
            dysk_was_active_reg <= 1'b0;
            cooldown_reg        <= '0;
        end else if (frame_end) begin
            tremor_run_reg      <= tremor_run_next;
            dysk_run_reg        <= dysk_run_next;
            dysk_was_active_reg <= dysk_was_active_next;
            cooldown_reg        <= cooldown_next;
        end
    end

endmodule

// ----- design/spectral_band_symptom_classifier.sv -----
// ----------------------------------------------------------------------------
// spectral_band_symptom_classifier
// Tracks peak magnitudes of a tremor band and a dyskinesia band over one
// spectrum frame and classifies the frame on its last bin.
//
//   channel | direction | handshake          | contents
//   s_      | in        | s_tvalid/s_tready  | one bin: index, magnitude, tlast
//   m_      | out       | m_tvalid/m_tready  | one verdict per frame with peaks
//   cfg_    | in        | cfg_valid/cfg_ready| register index, write data
//
// One bin per cycle unless a last bin is held; each bin passes the input
// register, and the verdict enters the result register as the last bin
// leaves it. cfg_ready is always high. Reset (aresetn low, synchronous)
// restores register defaults and clears peaks, runs and cooldown. An untaken
// verdict holds the next last bin, and all bins behind it; earlier bins flow.
// ----------------------------------------------------------------------------
module spectral_band_symptom_classifier #(
    parameter int COOLDOWN_FRAMES = sbsc_pkg::DefCooldownFrames
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [4:0] bin_index, [24:5] magnitude, [31:25] zero
    input  logic [sbsc_pkg::InDataWidth-1:0]     s_tdata,
    input  logic                                 s_tlast,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] symptom, [3:2] intensity, [5:4] intensity_led_mode,
    // [25:6] tremor_peak, [45:26] dysk_peak, [47:46] zero
    output logic [sbsc_pkg::OutDataWidth-1:0]    m_tdata,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sbsc_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [sbsc_pkg::CfgDataWidth-1:0]    cfg_data
);

    localparam int BW = sbsc_pkg::BinWidth;
    localparam int MW = sbsc_pkg::MagWidth;
    localparam int RW = sbsc_pkg::RunWidth;

    // Configuration registers
    logic [BW-1:0] tremor_lo_reg, tremor_hi_reg, dysk_lo_reg, dysk_hi_reg;
    logic [MW-1:0] th_low_reg, th_medium_reg, th_high_reg;
    logic [RW-1:0] min_consec_reg;

    // Input register
    logic          in_valid_reg, in_valid_next;
    logic [BW-1:0] in_bin_reg;
    logic [MW-1:0] in_mag_reg;
    logic          in_last_reg;

    // Frame peaks
    logic [MW-1:0] tremor_peak_reg, tremor_peak_next;
    logic [MW-1:0] dysk_peak_reg, dysk_peak_next;

    // Result register
    logic                 m_valid_reg, m_valid_next;
    sbsc_pkg::verdict_t   m_verdict_reg;
    logic [MW-1:0]        m_tremor_peak_reg, m_dysk_peak_reg;

    logic                 s_accept;
    logic                 out_busy;
    logic                 advance;
    logic                 frame_end;
    logic                 bin_ok;
    logic                 tremor_take, dysk_take;
    sbsc_pkg::band_stat_t tremor_stat, dysk_stat;
    sbsc_pkg::verdict_t   verdict;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tremor_lo_reg  <= BW'(4);
            tremor_hi_reg  <= BW'(6);
            dysk_lo_reg    <= BW'(7);
            dysk_hi_reg    <= BW'(8);
            th_low_reg     <= MW'(2400);
            th_medium_reg  <= MW'(6400);
            th_high_reg    <= MW'(12800);
            min_consec_reg <= RW'(3);
        end else if (cfg_valid && cfg_ready) begin
            unique case (sbsc_pkg::cfg_index_t'(cfg_index))
                sbsc_pkg::REG_TREMOR_BIN_LOW:  tremor_lo_reg  <= cfg_data[BW-1:0];
                sbsc_pkg::REG_TREMOR_BIN_HIGH: tremor_hi_reg  <= cfg_data[BW-1:0];
                sbsc_pkg::REG_DYSK_BIN_LOW:    dysk_lo_reg    <= cfg_data[BW-1:0];
                sbsc_pkg::REG_DYSK_BIN_HIGH:   dysk_hi_reg    <= cfg_data[BW-1:0];
                sbsc_pkg::REG_THRESH_LOW:      th_low_reg     <= cfg_data[MW-1:0];
                sbsc_pkg::REG_THRESH_MEDIUM:   th_medium_reg  <= cfg_data[MW-1:0];
                sbsc_pkg::REG_THRESH_HIGH:     th_high_reg    <= cfg_data[MW-1:0];
                sbsc_pkg::REG_MIN_CONSECUTIVE: min_consec_reg <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: a last bin may only leave the input register when the
    // result register is free or being drained this cycle
    assign out_busy  = m_valid_reg && !m_tready;
    assign advance   = in_valid_reg && !(in_last_reg && out_busy);
    assign frame_end = advance && in_last_reg;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_accept || (in_valid_reg && !advance);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_bin_reg  <= s_tdata[BW-1:0];
            in_mag_reg  <= s_tdata[BW+MW-1:BW];
            in_last_reg <= s_tlast;
        end
    end

    // Fold the bin into both peaks; the band figures are taken from the
    // magnitude or the old peak in parallel and picked afterward
    always_comb begin
        bin_ok = (in_bin_reg != '0) && (32'(in_bin_reg) < 32'(sbsc_pkg::SpectrumBins));
        tremor_take = bin_ok && (in_bin_reg >= tremor_lo_reg) && (in_bin_reg <= tremor_hi_reg)
                      && (in_mag_reg > tremor_peak_reg);
        dysk_take   = bin_ok && (in_bin_reg >= dysk_lo_reg) && (in_bin_reg <= dysk_hi_reg)
                      && (in_mag_reg > dysk_peak_reg);

        tremor_stat.detect = tremor_take ? (in_mag_reg > th_low_reg)
                                         : (tremor_peak_reg > th_low_reg);
        tremor_stat.level  = tremor_take
            ? sbsc_pkg::level_of(in_mag_reg, th_low_reg, th_medium_reg, th_high_reg)
            : sbsc_pkg::level_of(tremor_peak_reg, th_low_reg, th_medium_reg, th_high_reg);
        dysk_stat.detect   = dysk_take ? (in_mag_reg > th_low_reg)
                                       : (dysk_peak_reg > th_low_reg);
        dysk_stat.level    = dysk_take
            ? sbsc_pkg::level_of(in_mag_reg, th_low_reg, th_medium_reg, th_high_reg)
            : sbsc_pkg::level_of(dysk_peak_reg, th_low_reg, th_medium_reg, th_high_reg);

        tremor_peak_next = tremor_take ? in_mag_reg : tremor_peak_reg;
        dysk_peak_next   = dysk_take ? in_mag_reg : dysk_peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tremor_peak_reg <= '0;
            dysk_peak_reg   <= '0;
        end else if (frame_end) begin
            tremor_peak_reg <= '0;
            dysk_peak_reg   <= '0;
        end else if (advance) begin
            tremor_peak_reg <= tremor_peak_next;
            dysk_peak_reg   <= dysk_peak_next;
        end
    end

    sbsc_decide #(
        .COOLDOWN_FRAMES (COOLDOWN_FRAMES)
    ) u_decide (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .frame_end       (frame_end),
        .min_consecutive (min_consec_reg),
        .tremor_stat     (tremor_stat),
        .dysk_stat       (dysk_stat),
        .verdict         (verdict)
    );

    always_comb begin
        priority if (frame_end) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_end) begin
            m_verdict_reg     <= verdict;
            m_tremor_peak_reg <= tremor_peak_next;
            m_dysk_peak_reg   <= dysk_peak_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_dysk_peak_reg, m_tremor_peak_reg,
                       m_verdict_reg.led_mode, m_verdict_reg.intensity,
                       m_verdict_reg.symptom};

endmodule

// ----- design/sbsc_checker.sv -----
// ----------------------------------------------------------------------------
// sbsc_port_props
// Port-level checks on the classifier's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sbsc_port_props (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [sbsc_pkg::OutDataWidth-1:0] m_tdata
);

    // A stalled transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction changed while stalled");

    // No symptom means no intensity and LED off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == sbsc_pkg::SYM_NONE) |-> (m_tdata[5:2] == 4'd0))
        else $error("intensity or LED set without a symptom");

    // LED mode follows intensity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:2] == sbsc_pkg::LVL_HIGH) == (m_tdata[5:4] == sbsc_pkg::LED_SOLID))
                  && ((m_tdata[3:2] == sbsc_pkg::LVL_MEDIUM)
                      == (m_tdata[5:4] == sbsc_pkg::LED_BLINK)))
        else $error("LED mode disagrees with intensity");

    // Nothing shows right after reset releases
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind spectral_band_symptom_classifier sbsc_port_props u_sbsc_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
